>>> design/rc_pulse_axis_target_defines.svh
// ----------------------------------------------------------------------------
// rc_pulse_axis_target_defines.svh
// Assertion macros for the RC axis target block, included by rc_pulse_axis_target.sv.
// ----------------------------------------------------------------------------
`ifndef RC_PULSE_AXIS_TARGET_DEFINES_SVH
`define RC_PULSE_AXIS_TARGET_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RCPAT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcpat: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RCPAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcpat: assertion failed");

`endif

>>> design/rcpat_pkg.sv
// ----------------------------------------------------------------------------
// rcpat_pkg
// Types, constants and register codes for the RC axis target block.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpat_pkg;

  // Pulse timing constants, in timer ticks.
  localparam int MID_WIDTH  = 24000;
  localparam int DEAD_BAND  = 80;
  localparam int FULL_RANGE = 16000;

  // Integrating-mode scale divisor and its reciprocal.
  localparam int          SLEW_DIV    = FULL_RANGE / 2;
  localparam int          PROD_W      = 31;
  localparam int          RECIP_SHIFT = 31;
  localparam longint      RECIP_L     = (64'd1 << RECIP_SHIFT) / SLEW_DIV;
  localparam int          RECIP_W     = $clog2(RECIP_L + 1);
  localparam int          QUO_W       = $clog2(((64'd1 << PROD_W) - 1) / SLEW_DIV + 1);
  localparam int          SUM_W       = ((QUO_W + 1) > 16 ? (QUO_W + 1) : 16) + 1;
  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_L);
  localparam logic [PROD_W-1:0]  DIV_C  = PROD_W'(SLEW_DIV);

  // Wrapped 16-bit offsets of the pulse width thresholds.
  localparam logic [15:0] MID16 = 16'(((MID_WIDTH % 65536) + 65536) % 65536);
  localparam logic [15:0] HI16  = 16'((((MID_WIDTH + DEAD_BAND) % 65536) + 65536) % 65536);
  localparam logic [15:0] LO16  = 16'((((MID_WIDTH - DEAD_BAND) % 65536) + 65536) % 65536);

  // Absolute-mode filter: new = (off + old * FILT_NUM) / FILT_DEN.
  localparam int FILT_NUM   = 1023;
  localparam int FILT_DEN   = 1024;
  localparam int FILT_SHIFT = $clog2(FILT_DEN);
  localparam int FILT_W     = 28;

  typedef enum logic {
    OP_PIN  = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_SLEW      = 3'd1,
    REG_MAX_ANGLE = 3'd2,
    REG_MIN_ANGLE = 3'd3,
    REG_MID_ANGLE = 3'd4,
    REG_DEF_ANGLE = 3'd5,
    REG_TIMEOUT   = 3'd6
  } reg_idx_t;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  typedef struct packed {
    op_t         op;
    logic        pin_level;
    logic [15:0] time_stamp;
  } item_t;

  typedef struct packed {
    logic signed [15:0] target_angle;
    logic               timed_out;
  } result_t;

  typedef struct packed {
    logic               mode_absolute;
    logic [14:0]        max_slew_rate;
    logic signed [15:0] max_angle;
    logic signed [15:0] min_angle;
    logic signed [15:0] mid_angle;
    logic signed [15:0] default_angle;
    logic [15:0]        timeout_limit;
  } cfg_t;

  // Evaluate tick as it reaches the final update stage.
  typedef struct packed {
    logic                   done;
    logic                   hold;
    logic signed [QUO_W:0]  step;
    logic signed [15:0]     offset;
  } tail_t;

  typedef struct packed {
    logic [15:0]        miss_count;
    logic signed [15:0] target_value;
    logic signed [15:0] smoothed_offset;
  } axis_state_t;

endpackage

`default_nettype wire

>>> design/rcpat_update.sv
// ----------------------------------------------------------------------------
// rcpat_update
// Final update of the axis state for one evaluate tick.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpat_update (
  input  var rcpat_pkg::cfg_t        cfg,
  input  var rcpat_pkg::tail_t       tail,
  input  var rcpat_pkg::axis_state_t axis,
  output rcpat_pkg::axis_state_t     axis_next,
  output rcpat_pkg::result_t         result
);

  localparam int SW = rcpat_pkg::SUM_W;
  localparam int FW = rcpat_pkg::FILT_W;
  localparam logic signed [FW-1:0] FNUM = FW'(rcpat_pkg::FILT_NUM);
  localparam logic signed [FW-1:0] FBIAS = FW'(rcpat_pkg::FILT_DEN - 1);

  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] max_ext;
  logic signed [SW-1:0] min_ext;
  logic signed [SW-1:0] clip_hi;
  logic signed [SW-1:0] clip;
  logic signed [FW-1:0] acc;
  logic signed [FW-1:0] filt;
  logic signed [15:0]   smooth_new;

  // Integrating path: add the scaled step, clamp high first, then low.
  assign sum = SW'(axis.target_value) + SW'(tail.step);
  assign max_ext = SW'(cfg.max_angle);
  assign min_ext = SW'(cfg.min_angle);
  assign clip_hi = (sum > max_ext) ? max_ext : sum;
  assign clip = (clip_hi < min_ext) ? min_ext : clip_hi;

  // Absolute path: IIR with division truncating toward zero.
  assign acc = FW'(tail.offset) + FW'(axis.smoothed_offset) * FNUM;
  assign filt = acc[FW-1] ? ((acc + FBIAS) >>> rcpat_pkg::FILT_SHIFT)
                          : (acc >>> rcpat_pkg::FILT_SHIFT);
  assign smooth_new = filt[15:0];

  always_comb begin
    axis_next = axis;
    result.timed_out = 1'b0;
    if (tail.done) begin
      axis_next.miss_count = '0;
      if (cfg.mode_absolute) begin
        axis_next.smoothed_offset = smooth_new;
        axis_next.target_value = smooth_new + cfg.mid_angle;
      end else if (!tail.hold) begin
        axis_next.target_value = clip[15:0];
      end
    end else if (axis.miss_count >= cfg.timeout_limit) begin
      axis_next.target_value = cfg.default_angle;
      result.timed_out = 1'b1;
    end else begin
      axis_next.miss_count = axis.miss_count + 16'd1;
    end
    result.target_angle = axis_next.target_value;
  end

endmodule

`default_nettype wire

>>> design/rc_pulse_axis_target.sv
// ----------------------------------------------------------------------------
// rc_pulse_axis_target
// One RC servo axis: pulse width decoding and target angle generation.
//
// The block takes one item per clock while item_stall is low: pin-change
// samples update the pulse latch at the edge where they are accepted and give
// no result, while each evaluate tick gives one result after passing through
// five registers in a row (the input stage, a 15x16 gain multiply, a
// reciprocal multiply for the division by half the full range, the quotient
// correction, and the state update into the output register). The four
// pipeline stages and the output register advance independently, so an item
// is only refused when all of them are full and the output is stalled.
// Configuration is written over the APB port at byte address 4*i and must
// only change while no tick is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rc_pulse_axis_target_defines.svh"

module rc_pulse_axis_target (
  input  wire                    clk,
  input  wire                    rst,
  // Item channel.
  input  wire                    item_valid,
  output logic                   item_stall,
  input  var rcpat_pkg::item_t   item,
  // Result channel.
  output logic                   result_valid,
  input  wire                    result_stall,
  output rcpat_pkg::result_t     result,
  // Register port.
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [4:0]             paddr,
  input  wire  [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int PW = rcpat_pkg::PROD_W;
  localparam int QW = rcpat_pkg::QUO_W;
  localparam int RW = rcpat_pkg::RECIP_W;

  typedef struct packed {
    logic               done;
    logic               hold;
    logic               neg;
    logic [15:0]        mag;
    logic signed [15:0] offset;
  } s1_t;

  typedef struct packed {
    logic               done;
    logic               hold;
    logic               neg;
    logic [PW-1:0]      prod;
    logic signed [15:0] offset;
  } s2_t;

  typedef struct packed {
    logic               done;
    logic               hold;
    logic               neg;
    logic [PW-1:0]      prod;
    logic [QW-1:0]      quo;
    logic signed [15:0] offset;
  } s3_t;

  // Configuration registers.
  rcpat_pkg::cfg_t cfg;
  logic            cfg_write;

  // Pulse latch state.
  logic        last_level;
  logic [15:0] stamp_or_width;
  logic        pulse_done;

  // Axis state owned by the final stage.
  rcpat_pkg::axis_state_t axis;
  rcpat_pkg::axis_state_t axis_next;
  rcpat_pkg::result_t     result_next;

  // Pipeline stages.
  logic             v1, v2, v3, v4;
  logic             ld1, ld2, ld3, ld4, ld5;
  s1_t              s1;
  s1_t              s1_next;
  s2_t              s2;
  s3_t              s3;
  rcpat_pkg::tail_t s4;
  rcpat_pkg::tail_t s4_next;

  logic             item_take;
  logic             eval_take;
  logic [15:0]      above;
  logic [15:0]      below;
  logic             pos;
  logic [15:0]      live;
  logic [PW+RW-1:0] recip_prod;
  logic [PW-1:0]    rem;
  logic [QW-1:0]    quo_fix;

  // --------------------------------------------------------------------------
  // Register port. Writes land on the access phase; reads are combinational.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_absolute <= 1'b0;
      cfg.max_slew_rate <= '0;
      cfg.max_angle     <= '0;
      cfg.min_angle     <= '0;
      cfg.mid_angle     <= '0;
      cfg.default_angle <= '0;
      cfg.timeout_limit <= rcpat_pkg::TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (rcpat_pkg::reg_idx_t'(paddr[4:2]))
        rcpat_pkg::REG_MODE:      cfg.mode_absolute <= pwdata[0];
        rcpat_pkg::REG_SLEW:      cfg.max_slew_rate <= pwdata[14:0];
        rcpat_pkg::REG_MAX_ANGLE: cfg.max_angle     <= pwdata[15:0];
        rcpat_pkg::REG_MIN_ANGLE: cfg.min_angle     <= pwdata[15:0];
        rcpat_pkg::REG_MID_ANGLE: cfg.mid_angle     <= pwdata[15:0];
        rcpat_pkg::REG_DEF_ANGLE: cfg.default_angle <= pwdata[15:0];
        rcpat_pkg::REG_TIMEOUT:   cfg.timeout_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rcpat_pkg::reg_idx_t'(paddr[4:2]))
      rcpat_pkg::REG_MODE:      prdata = {31'd0, cfg.mode_absolute};
      rcpat_pkg::REG_SLEW:      prdata = {17'd0, cfg.max_slew_rate};
      rcpat_pkg::REG_MAX_ANGLE: prdata = {{16{cfg.max_angle[15]}}, cfg.max_angle};
      rcpat_pkg::REG_MIN_ANGLE: prdata = {{16{cfg.min_angle[15]}}, cfg.min_angle};
      rcpat_pkg::REG_MID_ANGLE: prdata = {{16{cfg.mid_angle[15]}}, cfg.mid_angle};
      rcpat_pkg::REG_DEF_ANGLE: prdata = {{16{cfg.default_angle[15]}}, cfg.default_angle};
      rcpat_pkg::REG_TIMEOUT:   prdata = {16'd0, cfg.timeout_limit};
      default:                  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control. Each stage loads when it is empty or its item moves on, so
  // bubbles collapse and the input keeps flowing behind a stalled result.
  // --------------------------------------------------------------------------
  assign ld5 = !result_valid || !result_stall;
  assign ld4 = !v4 || ld5;
  assign ld3 = !v3 || ld4;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;
  assign item_stall = !ld1;
  assign item_take = item_valid && ld1;
  assign eval_take = item_take && (item.op == rcpat_pkg::OP_EVAL);

  // --------------------------------------------------------------------------
  // Pulse latch. Pin samples act at acceptance, so every tick behind them
  // sees the width they leave, and every tick before them has its snapshot.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level     <= 1'b0;
      stamp_or_width <= '0;
      pulse_done     <= 1'b0;
    end else if (item_take && (item.op == rcpat_pkg::OP_PIN)) begin
      last_level <= item.pin_level;
      if (item.pin_level != last_level) begin
        if (item.pin_level) begin
          stamp_or_width <= item.time_stamp;
          pulse_done     <= 1'b0;
        end else begin
          stamp_or_width <= item.time_stamp - stamp_or_width;
          pulse_done     <= 1'b1;
        end
      end
    end
  end

  // Stick offset outside the deadband: positive above the upper threshold,
  // negative below the lower one, held in between (all with 16-bit wrap).
  assign above = stamp_or_width - rcpat_pkg::HI16;
  assign below = stamp_or_width - rcpat_pkg::LO16;
  assign pos   = !above[15] && (above != 16'd0);
  assign live  = pos ? above : below;

  always_comb begin
    s1_next.done   = pulse_done;
    s1_next.hold   = !pos && !below[15];
    s1_next.neg    = !pos;
    s1_next.mag    = pos ? live : (16'd0 - live);
    s1_next.offset = stamp_or_width - rcpat_pkg::MID16;
  end

  // --------------------------------------------------------------------------
  // Scaling pipeline: |offset| * gain, then divide by half the full range
  // through a reciprocal estimate that is low by at most one, then correct.
  // --------------------------------------------------------------------------
  assign recip_prod = (PW + RW)'(s2.prod) * (PW + RW)'(rcpat_pkg::RECIP);
  assign rem = s3.prod - PW'(s3.quo) * rcpat_pkg::DIV_C;
  assign quo_fix = s3.quo + QW'(rem >= rcpat_pkg::DIV_C);

  always_comb begin
    s4_next.done   = s3.done;
    s4_next.hold   = s3.hold;
    s4_next.offset = s3.offset;
    s4_next.step   = s3.neg ? -$signed({1'b0, quo_fix}) : $signed({1'b0, quo_fix});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ld1) v1 <= eval_take;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && eval_take) begin
      s1 <= s1_next;
    end
    if (ld2 && v1) begin
      s2.done   <= s1.done;
      s2.hold   <= s1.hold;
      s2.neg    <= s1.neg;
      s2.offset <= s1.offset;
      s2.prod   <= PW'(cfg.max_slew_rate) * PW'(s1.mag);
    end
    if (ld3 && v2) begin
      s3.done   <= s2.done;
      s3.hold   <= s2.hold;
      s3.neg    <= s2.neg;
      s3.offset <= s2.offset;
      s3.prod   <= s2.prod;
      s3.quo    <= recip_prod[rcpat_pkg::RECIP_SHIFT +: QW];
    end
    if (ld4 && v3) begin
      s4 <= s4_next;
    end
  end

  // --------------------------------------------------------------------------
  // Final stage: axis state update and the result register.
  // --------------------------------------------------------------------------
  rcpat_update u_update (
    .cfg       (cfg),
    .tail      (s4),
    .axis      (axis),
    .axis_next (axis_next),
    .result    (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      axis         <= '0;
    end else if (ld5) begin
      result_valid <= v4;
      if (v4) begin
        axis <= axis_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld5 && v4) begin
      result <= result_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A timeout result always carries the default angle.
  `RCPAT_ASSERT_IMPLY(a_timeout_default, clk, rst,
    result_valid && result.timed_out, result.target_angle == cfg.default_angle)
  // A rising pin edge opens a new pulse.
  `RCPAT_ASSERT_NEXT(a_rise_clears_done, clk, rst,
    item_take && (item.op == rcpat_pkg::OP_PIN) && item.pin_level && !last_level,
    !pulse_done)
  // Items are refused only when every stage and the result register are full.
  `RCPAT_ASSERT_IMPLY(a_stall_only_full, clk, rst,
    item_stall, v1 && v2 && v3 && v4 && result_valid && result_stall)
  // A tick with a complete pulse restarts the miss count.
  `RCPAT_ASSERT_NEXT(a_done_clears_miss, clk, rst,
    v4 && ld5 && s4.done, axis.miss_count == 16'd0)

endmodule

`default_nettype wire

>>> verif/rc_pulse_axis_target_tb.sv
// ----------------------------------------------------------------------------
// rc_pulse_axis_target_tb
// Self-checking bench for the RC axis target block. A short hand-written plan
// (extreme register values, deadband edges, timeouts, wrap of the absolute
// filter) is followed by random phases. Each phase loads new register values
// and then sends mostly well-formed servo pulses with random content. Every
// result word is checked against a behavioral model of the channel that is
// kept inside this bench, or against the result given in a typed plan row.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_pulse_axis_target_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Servo pulse constants, in timer ticks, and the absolute-mode filter ratio.
  localparam int MID_TICKS  = 24000;
  localparam int BAND_TICKS = 80;
  localparam int HALF_RANGE = 8000;
  localparam int FILT_KEEP  = 1023;
  localparam int FILT_DIV   = 1024;

  // Idle drain period that settle() adds after the last expected result.
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASES       = 10;
  localparam int PHASE_WORDS  = 115;
  // Time limit; the slowest legal run is roughly 1200 words.
  localparam int RUN_LIMIT_NS = 5_000_000;

  typedef enum logic {
    ROW_WORD,
    ROW_REG
  } row_kind_t;

  // One line of the directed plan: either an input word or a register write.
  // Where typed is set, angle and tout are the result read straight off the
  // behavior; otherwise the result comes from the channel model.
  typedef struct packed {
    row_kind_t           kind;
    rcpat_pkg::reg_idx_t idx;
    rcpat_pkg::op_t      op;
    logic                lvl;
    logic [15:0]         val;
    logic                typed;
    logic [15:0]         angle;
    logic                tout;
  } plan_row_t;

  localparam int PLAN_ROWS = 37;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // Straight after reset: a miss that only counts up.
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_EVAL, 1'b0, 16'h0000, 1'b1, 16'h0000, 1'b0},
    // A low sample while the pin is already low changes nothing.
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_PIN, 1'b0, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    // A timeout limit of zero times out on the first miss.
    '{ROW_REG, rcpat_pkg::REG_TIMEOUT, rcpat_pkg::OP_PIN, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_EVAL, 1'b0, 16'h0000, 1'b1, 16'h0000, 1'b1},
    '{ROW_REG, rcpat_pkg::REG_DEF_ANGLE, rcpat_pkg::OP_PIN, 1'b0, 16'h8000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_EVAL, 1'b0, 16'h0000, 1'b1, 16'h8000, 1'b1},
    '{ROW_REG, rcpat_pkg::REG_DEF_ANGLE, rcpat_pkg::OP_PIN, 1'b0, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_EVAL, 1'b0, 16'h0000, 1'b1, 16'h7FFF, 1'b1},
    // Full gain and the widest clamp window.
    '{ROW_REG, rcpat_pkg::REG_SLEW, rcpat_pkg::OP_PIN, 1'b0, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_REG, rcpat_pkg::REG_MAX_ANGLE, rcpat_pkg::OP_PIN, 1'b0, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_REG, rcpat_pkg::REG_MIN_ANGLE, rcpat_pkg::OP_PIN, 1'b0, 16'h8000, 1'b0, 16'h0000, 1'b0},
    // Longest pulse, wrapping through the timer rollover, then a repeated
    // high sample that must be ignored.
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_PIN, 1'b1, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_PIN, 1'b1, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_PIN, 1'b0, 16'hFFFE, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_EVAL, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_EVAL, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    // Centered stick: inside the deadband the target holds.
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_PIN, 1'b1, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_PIN, 1'b0, 16'h5DC0, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_EVAL, 1'b0, 16'h0000, 1'b1, 16'h8000, 1'b0},
    // One tick past the upper deadband edge.
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_PIN, 1'b1, 16'h03E8, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_PIN, 1'b0, 16'h61F9, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_EVAL, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    // Absolute mode: a small offset vanishes in the filter, leaving mid_angle.
    '{ROW_REG, rcpat_pkg::REG_MODE, rcpat_pkg::OP_PIN, 1'b0, 16'h0001, 1'b0, 16'h0000, 1'b0},
    '{ROW_REG, rcpat_pkg::REG_MID_ANGLE, rcpat_pkg::OP_PIN, 1'b0, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_EVAL, 1'b0, 16'h0000, 1'b1, 16'h7FFF, 1'b0},
    // Zero width pulse, then the final sum wraps with the lowest mid_angle.
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_PIN, 1'b1, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_PIN, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_EVAL, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_REG, rcpat_pkg::REG_MID_ANGLE, rcpat_pkg::OP_PIN, 1'b0, 16'h8000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_EVAL, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    // Crossed clamps: min_angle wins over max_angle.
    '{ROW_REG, rcpat_pkg::REG_MODE, rcpat_pkg::OP_PIN, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_REG, rcpat_pkg::REG_MAX_ANGLE, rcpat_pkg::OP_PIN, 1'b0, 16'hFF9C, 1'b0, 16'h0000, 1'b0},
    '{ROW_REG, rcpat_pkg::REG_MIN_ANGLE, rcpat_pkg::OP_PIN, 1'b0, 16'h0064, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_EVAL, 1'b0, 16'h0000, 1'b1, 16'h0064, 1'b0},
    // Exactly on the lower deadband edge: still held.
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_PIN, 1'b1, 16'h0005, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_PIN, 1'b0, 16'h5D75, 1'b0, 16'h0000, 1'b0},
    '{ROW_WORD, rcpat_pkg::REG_MODE, rcpat_pkg::OP_EVAL, 1'b0, 16'h0000, 1'b1, 16'h0064, 1'b0}
  };

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  logic               item_stall;
  rcpat_pkg::item_t   item         = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  rcpat_pkg::result_t result;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [4:0]         paddr        = '0;
  logic [31:0]        pwdata       = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Channel model state and its copy of the registers.
  rcpat_pkg::cfg_t    cfg_now   = '{mode_absolute: 1'b0, max_slew_rate: '0, max_angle: '0,
                                    min_angle: '0, mid_angle: '0, default_angle: '0,
                                    timeout_limit: rcpat_pkg::TIMEOUT_RESET};
  logic               pin_last  = 1'b0;
  logic [15:0]        latch_w   = '0;
  logic               width_ok  = 1'b0;
  logic [15:0]        miss_n    = '0;
  logic signed [15:0] target_v  = '0;
  logic signed [15:0] smooth_v  = '0;

  rcpat_pkg::result_t due_angles [$];
  rcpat_pkg::result_t want;
  int                 words_live = 0;
  int                 errors     = 0;
  int                 gap_pct    = 30;
  int                 hold_pct   = 30;
  int                 hold_left  = 0;

  rc_pulse_axis_target i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // An idle stretch comes with the given percentage; one in ten is long. A percentage
  // of zero gives a stretch with no idling at all.
  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Pulse widths cluster around the stick range, with some right at the
  // deadband edges and some anywhere in the 16-bit timer range.
  function automatic logic [15:0] pulse_width();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 16'(MID_TICKS - 8000 + $urandom_range(0, 16000));
      6: return 16'(MID_TICKS - 120 + $urandom_range(0, 240));
      7: return 16'(MID_TICKS + ($urandom_range(0, 1) ? BAND_TICKS : -BAND_TICKS)
                    + $urandom_range(0, 2) - 1);
      8: return 16'($urandom);
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Channel model. Applies one accepted word to the state and returns 1 with
  // the result when the word is an evaluate tick.
  function automatic bit advance_axis(input rcpat_pkg::item_t it,
                                      output rcpat_pkg::result_t res);
    logic signed [15:0] off_w;
    int                 live;
    int                 filt;
    longint             sum;
    bit                 hold;
    res = '0;
    words_live++;
    if (it.op == rcpat_pkg::OP_PIN) begin
      if (it.pin_level != pin_last) begin
        // Rising edge latches the stamp; falling edge turns it into a width.
        if (it.pin_level) begin
          latch_w  = it.time_stamp;
          width_ok = 1'b0;
        end else begin
          latch_w  = it.time_stamp - latch_w;
          width_ok = 1'b1;
        end
      end
      pin_last = it.pin_level;
      return 1'b0;
    end
    if (width_ok) begin
      miss_n = '0;
      if (cfg_now.mode_absolute) begin
        off_w    = latch_w - 16'(MID_TICKS);
        filt     = (int'(off_w) + int'(smooth_v) * FILT_KEEP) / FILT_DIV;
        smooth_v = 16'(filt);
        target_v = smooth_v + cfg_now.mid_angle;
      end else begin
        // Offsets beyond the deadband are measured from its near edge.
        off_w = latch_w - 16'(MID_TICKS + BAND_TICKS);
        live  = off_w;
        hold  = 1'b0;
        if (live <= 0) begin
          off_w = latch_w - 16'(MID_TICKS - BAND_TICKS);
          live  = off_w;
          hold  = (live >= 0);
        end
        if (!hold) begin
          sum = longint'(target_v) + longint'(cfg_now.max_slew_rate) * live / HALF_RANGE;
          if (sum > cfg_now.max_angle) sum = cfg_now.max_angle;
          if (sum < cfg_now.min_angle) sum = cfg_now.min_angle;
          target_v = 16'(sum);
        end
      end
    end else if (miss_n >= cfg_now.timeout_limit) begin
      target_v      = cfg_now.default_angle;
      res.timed_out = 1'b1;
    end else begin
      miss_n = miss_n + 16'd1;
    end
    res.target_angle = target_v;
    return 1'b1;
  endfunction

  // Presents one word from a falling edge and holds it until the block takes
  // it. Returns at the falling edge after acceptance with valid still high,
  // so back-to-back words never lower and raise valid in the same step.
  task automatic send_word(input rcpat_pkg::item_t it, input bit typed,
                           input rcpat_pkg::result_t typed_res);
    int                 gap;
    rcpat_pkg::result_t res;
    gap = pick_gap(gap_pct);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    if (advance_axis(it, res)) due_angles.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // Stops sending and waits until every evaluate tick has been answered, then
  // idles for a drain period of DRAIN_CYCLES.
  task automatic settle();
    item_valid <= 1'b0;
    while (due_angles.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write, setup then access; the model's copy follows.
  task automatic write_reg(input rcpat_pkg::reg_idx_t idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    case (idx)
      rcpat_pkg::REG_MODE:      cfg_now.mode_absolute = val[0];
      rcpat_pkg::REG_SLEW:      cfg_now.max_slew_rate = val[14:0];
      rcpat_pkg::REG_MAX_ANGLE: cfg_now.max_angle     = val;
      rcpat_pkg::REG_MIN_ANGLE: cfg_now.min_angle     = val;
      rcpat_pkg::REG_MID_ANGLE: cfg_now.mid_angle     = val;
      rcpat_pkg::REG_DEF_ANGLE: cfg_now.default_angle = val;
      rcpat_pkg::REG_TIMEOUT:   cfg_now.timeout_limit = val;
      default: ;
    endcase
  endtask

  // Result side back-pressure: stalls of random length, changed only at the
  // falling edge so the block sees a stable value at each rising edge.
  always @(negedge clk) begin
    if (hold_left == 0) hold_left = pick_gap(hold_pct);
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Every word taken from the result channel is matched against the oldest
  // prediction. A word with nothing predicted is an error as well.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (due_angles.size() == 0) begin
        $display("%0t: unexpected result word: angle %0d timed_out %0b",
                 $time, result.target_angle, result.timed_out);
        errors++;
      end else begin
        want = due_angles.pop_front();
        if (result.target_angle !== want.target_angle ||
            result.timed_out !== want.timed_out) begin
          $display({"%0t: result mismatch: expected angle %0d timed_out %0b,",
                    " got angle %0d timed_out %0b"},
                   $time, want.target_angle, want.timed_out,
                   result.target_angle, result.timed_out);
          errors++;
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int          goal;
    int          pick;
    logic [15:0] t0;
    logic        cfg_mode;
    logic [15:0] cfg_slew;
    logic [15:0] mx;
    logic [15:0] mn;
    logic [15:0] mid;
    logic [15:0] dflt;
    logic [15:0] tmo;
    logic [15:0] swap;

    // Synchronous reset, released at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed plan. Register rows are only written once the block is idle.
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_REG) begin
        settle();
        write_reg(PLAN[i].idx, PLAN[i].val);
      end else begin
        send_word('{PLAN[i].op, PLAN[i].lvl, PLAN[i].val}, PLAN[i].typed,
                  '{PLAN[i].angle, PLAN[i].tout});
      end
    end

    // Random phases. The first two use the register extremes; every phase
    // begins with the sender paused until all results are back.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 0) begin
        cfg_mode = 1'b0;  cfg_slew = 16'h7FFF; mx = 16'h7FFF; mn = 16'h8000;
        mid = 16'h7FFF;   dflt = 16'h7FFF;     tmo = 16'hFFFF;
      end else if (p == 1) begin
        cfg_mode = 1'b1;  cfg_slew = 16'h0000; mx = 16'h8000; mn = 16'h7FFF;
        mid = 16'h8000;   dflt = 16'h8000;     tmo = 16'h0000;
      end else begin
        cfg_mode = 1'($urandom);
        cfg_slew = ($urandom_range(0, 3) == 0) ? 16'h7FFF : 16'($urandom_range(0, 32767));
        mx       = pick_angle();
        mn       = pick_angle();
        // Usually keep the clamp window in order; sometimes leave it crossed.
        if ($urandom_range(0, 3) != 0 && $signed(mn) > $signed(mx)) begin
          swap = mx;
          mx   = mn;
          mn   = swap;
        end
        mid  = pick_angle();
        dflt = pick_angle();
        case ($urandom_range(0, 3))
          0: tmo = 16'($urandom_range(0, 4));
          1: tmo = rcpat_pkg::TIMEOUT_RESET;
          2: tmo = 16'($urandom);
          default: tmo = 16'($urandom_range(5, 20));
        endcase
      end
      write_reg(rcpat_pkg::REG_MODE, {15'd0, cfg_mode});
      write_reg(rcpat_pkg::REG_SLEW, cfg_slew);
      write_reg(rcpat_pkg::REG_MAX_ANGLE, mx);
      write_reg(rcpat_pkg::REG_MIN_ANGLE, mn);
      write_reg(rcpat_pkg::REG_MID_ANGLE, mid);
      write_reg(rcpat_pkg::REG_DEF_ANGLE, dflt);
      write_reg(rcpat_pkg::REG_TIMEOUT, tmo);

      // Vary the idling from none at all to heavy on both sides.
      case (p % 4)
        0: begin gap_pct = 20; hold_pct = 20; end
        1: begin gap_pct = 50; hold_pct = 50; end
        2: begin gap_pct = 0;  hold_pct = 0;  end
        default: begin gap_pct = 10; hold_pct = 60; end
      endcase

      goal = words_live + PHASE_WORDS;
      while (words_live < goal) begin
        pick = $urandom_range(0, 99);
        t0   = 16'($urandom);
        if (pick < 65) begin
          // Complete pulse followed by one or more evaluate ticks.
          send_word('{rcpat_pkg::OP_PIN, 1'b1, t0}, 1'b0, '0);
          send_word('{rcpat_pkg::OP_PIN, 1'b0, t0 + pulse_width()}, 1'b0, '0);
          repeat ($urandom_range(1, 3))
            send_word('{rcpat_pkg::OP_EVAL, 1'($urandom), 16'($urandom)}, 1'b0, '0);
        end else if (pick < 80) begin
          // Pulse that never ends: the ticks count as misses toward the timeout.
          send_word('{rcpat_pkg::OP_PIN, 1'b1, t0}, 1'b0, '0);
          repeat ($urandom_range(1, 6))
            send_word('{rcpat_pkg::OP_EVAL, 1'($urandom), 16'($urandom)}, 1'b0, '0);
        end else if (pick < 92) begin
          send_word('{rcpat_pkg::OP_PIN, 1'($urandom), t0}, 1'b0, '0);
        end else begin
          send_word(rcpat_pkg::item_t'(18'($urandom)), 1'b0, '0);
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
